// ===== hw/rtl/pdd_pkg.sv =====
// Shared types and constants for the pose detection decoder.
`default_nettype none
package pdd_pkg;

  localparam int PAD_W       = 12;
  localparam int INV_W       = 20;
  localparam int SIZE_W      = 14;
  localparam int THR_W       = 13;
  localparam int VALUE_W     = 17;
  localparam int SCORE_IN_W  = 16;
  localparam int SCORE_W     = 15;
  localparam int POINT_W     = 17;
  localparam int NUMBER_W    = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int SCALE_FRAC  = 16;

  localparam logic [SIZE_W-1:0]     IMAGE_MAX = 14'd8192;
  localparam logic [SCORE_IN_W-1:0] CONF_ONE  = 16'd4096;

  typedef enum logic [0:0] {
    OP_BOX      = 1'b0,
    OP_KEYPOINT = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAD_LEFT        = 3'd0,
    REG_PAD_TOP         = 3'd1,
    REG_INVERSE_SCALE   = 3'd2,
    REG_IMAGE_WIDTH     = 3'd3,
    REG_IMAGE_HEIGHT    = 3'd4,
    REG_SCORE_THRESHOLD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PAD_W-1:0]  pad_left;
    logic [PAD_W-1:0]  pad_top;
    logic [INV_W-1:0]  inverse_scale;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
    logic [THR_W-1:0]  score_threshold;
  } cfg_t;

  typedef struct packed {
    op_t                           op;
    logic                          drop;
    logic                          not_finite;
    logic signed [SCORE_IN_W-1:0]  score_in;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic [SIZE_W-1:0]  left;
    logic [SIZE_W-1:0]  top;
    logic [SIZE_W-1:0]  right;
    logic [SIZE_W-1:0]  bottom;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;
  } stage_t;

  typedef struct packed {
    op_t                 kind;
    logic [NUMBER_W-1:0] point_number;
    logic [SIZE_W-1:0]   box_left;
    logic [SIZE_W-1:0]   box_top;
    logic [SIZE_W-1:0]   box_right;
    logic [SIZE_W-1:0]   box_bottom;
    logic [POINT_W-1:0]  point_x;
    logic [POINT_W-1:0]  point_y;
    logic [SCORE_W-1:0]  score;
    logic                point_present;
    logic                last_of_prediction;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pdd_config.sv =====
// Configuration register file of the pose detection decoder.
`default_nettype none
module pdd_config (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pdd_pkg::cfg_t                    cfg
);
  import pdd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_left        <= '0;
      cfg.pad_top         <= '0;
      cfg.inverse_scale   <= 20'd65536;
      cfg.image_width     <= 14'd640;
      cfg.image_height    <= 14'd640;
      cfg.score_threshold <= 13'd1434;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAD_LEFT:        cfg.pad_left        <= cfg_data[PAD_W-1:0];
        REG_PAD_TOP:         cfg.pad_top         <= cfg_data[PAD_W-1:0];
        REG_INVERSE_SCALE:   cfg.inverse_scale   <= cfg_data[INV_W-1:0];
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[SIZE_W-1:0];
        REG_SCORE_THRESHOLD: cfg.score_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pdd_lane.sv =====
// One coordinate lane: un-pad, scale, clamp and round over three register stages.
`default_nettype none
module pdd_lane #(
  parameter int COORD_FRACTION_BITS = 4
) (
  input  logic                                   clk,
  input  logic signed [pdd_pkg::VALUE_W+1:0]     value,
  input  logic                                   is_point,
  input  logic [pdd_pkg::PAD_W-1:0]              pad,
  input  logic [pdd_pkg::INV_W-1:0]              inverse_scale,
  input  logic [pdd_pkg::SIZE_W-1:0]             image_size,
  input  logic                                   load_b,
  input  logic                                   load_c,
  input  logic                                   load_d,
  output logic [pdd_pkg::SIZE_W-1:0]             edge_floor,
  output logic [pdd_pkg::SIZE_W-1:0]             edge_ceil,
  output logic [pdd_pkg::POINT_W-1:0]            point
);
  import pdd_pkg::*;

  localparam int F       = COORD_FRACTION_BITS;
  localparam int V_W     = VALUE_W + 2;
  localparam int PADS_W  = PAD_W + F + 1;
  localparam int DIFF_W  = ((V_W > PADS_W + 1) ? V_W : PADS_W + 1) + 1;
  localparam int PROD_W  = DIFF_W + INV_W + 1;
  localparam int SH      = F + 1 + SCALE_FRAC;
  localparam int CLAMP_W = SIZE_W + SH;
  localparam int CMP_W   = (PROD_W > CLAMP_W + 1) ? PROD_W : CLAMP_W + 1;
  localparam int PT_W    = CLAMP_W - (SCALE_FRAC + 1);

  logic [PADS_W-1:0]          pad_shift;
  logic signed [DIFF_W-1:0]   diff_next;
  logic signed [DIFF_W-1:0]   diff;
  logic                       is_point_b;
  logic signed [PROD_W-1:0]   prod;
  logic                       is_point_c;
  logic [SIZE_W-1:0]          limit;
  logic [SIZE_W-1:0]          lim;
  logic [CLAMP_W-1:0]         hi;
  logic [CLAMP_W-1:0]         clamped;
  logic [SIZE_W-1:0]          floor_next;
  logic [SIZE_W-1:0]          ceil_next;
  logic [PT_W+POINT_W-1:0]    point_ext;
  logic [POINT_W-1:0]         point_next;

  // Value and padding both carry one more fraction bit than the input fields.
  assign pad_shift = {pad, {(F + 1){1'b0}}};
  assign diff_next = DIFF_W'(value) - $signed(DIFF_W'(pad_shift));

  always_ff @(posedge clk) begin
    if (load_b) begin
      diff       <= diff_next;
      is_point_b <= is_point;
    end
    if (load_c) begin
      prod       <= diff * $signed({1'b0, inverse_scale});
      is_point_c <= is_point_b;
    end
  end

  always_comb begin
    limit = (image_size > IMAGE_MAX) ? IMAGE_MAX : image_size;
    if (is_point_c) begin
      lim = (limit == '0) ? '0 : limit - SIZE_W'(1);
    end else begin
      lim = limit;
    end
    hi = {lim, {SH{1'b0}}};
    if (prod[PROD_W-1]) begin
      clamped = '0;
    end else if (CMP_W'(prod) > $signed(CMP_W'(hi))) begin
      clamped = hi;
    end else begin
      clamped = CLAMP_W'(prod);
    end
    floor_next = clamped[CLAMP_W-1:SH];
    ceil_next  = floor_next + SIZE_W'(|clamped[SH-1:0]);
    point_ext  = {{POINT_W{1'b0}}, clamped[CLAMP_W-1:SCALE_FRAC+1]};
    if (|point_ext[PT_W+POINT_W-1:POINT_W]) begin
      point_next = '1;
    end else begin
      point_next = point_ext[POINT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      edge_floor <= floor_next;
      edge_ceil  <= ceil_next;
      point      <= point_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pdd_decide.sv =====
// Prediction state, accept or drop decision and the output register.
`default_nettype none
module pdd_decide #(
  parameter int KEYPOINT_COUNT = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_d,
  input  pdd_pkg::stage_t   stage,
  output logic              take_d,
  output logic              out_valid,
  input  logic              out_ready,
  output pdd_pkg::result_t  result
);
  import pdd_pkg::*;

  localparam logic [NUMBER_W:0] COUNT = (NUMBER_W + 1)'(KEYPOINT_COUNT);

  logic                accepted;
  logic                accepted_next;
  logic [NUMBER_W-1:0] counter;
  logic [NUMBER_W-1:0] counter_next;
  logic [NUMBER_W:0]   count_inc;
  logic                box_keep;
  logic                emit;
  logic                out_space;
  logic                advance;
  result_t             result_next;

  always_comb begin
    box_keep      = !stage.meta.drop && (stage.right > stage.left) &&
                    (stage.bottom > stage.top);
    count_inc     = {1'b0, counter} + (NUMBER_W + 1)'(1);
    emit          = 1'b0;
    accepted_next = accepted;
    counter_next  = counter;
    result_next   = '0;
    if (stage.meta.op == OP_BOX) begin
      counter_next           = '0;
      accepted_next          = box_keep;
      emit                   = box_keep;
      result_next.kind       = OP_BOX;
      result_next.box_left   = stage.left;
      result_next.box_top    = stage.top;
      result_next.box_right  = stage.right;
      result_next.box_bottom = stage.bottom;
      result_next.score      = stage.meta.score_in[SCORE_W-1:0];
    end else if (accepted) begin
      emit                     = 1'b1;
      result_next.kind         = OP_KEYPOINT;
      result_next.point_number = counter;
      if (!stage.meta.not_finite) begin
        result_next.point_x       = stage.point_x;
        result_next.point_y       = stage.point_y;
        result_next.point_present = 1'b1;
        if (stage.meta.score_in[SCORE_IN_W-1]) begin
          result_next.score = '0;
        end else if (stage.meta.score_in > $signed(CONF_ONE)) begin
          result_next.score = CONF_ONE[SCORE_W-1:0];
        end else begin
          result_next.score = stage.meta.score_in[SCORE_W-1:0];
        end
      end
      if (count_inc >= COUNT) begin
        result_next.last_of_prediction = 1'b1;
        counter_next                   = '0;
        accepted_next                  = 1'b0;
      end else begin
        counter_next = count_inc[NUMBER_W-1:0];
      end
    end
  end

  assign out_space = !out_valid || out_ready;
  assign advance   = valid_d && (!emit || out_space);
  assign take_d    = !valid_d || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted  <= 1'b0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        accepted <= accepted_next;
        counter  <= counter_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pose_detection_decode_top.sv =====
// Top level of the pose detection decoder.
//
// Words arrive on the input channel as one box group followed by the keypoint
// triples of that prediction. Each accepted word gives at most one result word
// on the output channel, in order. A dropped box, and every keypoint that
// follows it, gives no result at all.
// Configuration registers are written through the cfg channel, index and data;
// the user must write them only while the decoder is idle; the block does not
// enforce this, and the channel is always ready. A word passes an input
// register, a subtract stage, a multiply stage, a clamp and round stage and
// the output register. One word can be taken every cycle while the output is
// not stalled; the four coordinate multipliers work in parallel.
// When the receiver stalls, words that give no result still drain and empty
// stages keep filling, so the input holds ready until every stage is full.
// Reset clears the stage valid bits, the prediction state and the output
// valid, and puts every configuration register at its default.
`default_nettype none
module pose_detection_decode_top #(
  parameter int KEYPOINT_COUNT      = 17,
  parameter int COORD_FRACTION_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pdd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [pdd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  operation,
  input  logic signed [pdd_pkg::VALUE_W-1:0]    value_a,
  input  logic signed [pdd_pkg::VALUE_W-1:0]    value_b,
  input  logic signed [pdd_pkg::VALUE_W-1:0]    value_c,
  input  logic signed [pdd_pkg::VALUE_W-1:0]    value_d,
  input  logic signed [pdd_pkg::SCORE_IN_W-1:0] score_in,
  input  logic                                  not_finite,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  kind,
  output logic [pdd_pkg::NUMBER_W-1:0]          point_number,
  output logic [pdd_pkg::SIZE_W-1:0]            box_left,
  output logic [pdd_pkg::SIZE_W-1:0]            box_top,
  output logic [pdd_pkg::SIZE_W-1:0]            box_right,
  output logic [pdd_pkg::SIZE_W-1:0]            box_bottom,
  output logic [pdd_pkg::POINT_W-1:0]           point_x,
  output logic [pdd_pkg::POINT_W-1:0]           point_y,
  output logic [pdd_pkg::SCORE_W-1:0]           score,
  output logic                                  point_present,
  output logic                                  last_of_prediction
);
  import pdd_pkg::*;

  localparam int V_W = VALUE_W + 2;

  cfg_t    cfg;
  logic    valid_a, valid_b, valid_c, valid_d;
  logic    take_a, take_b, take_c, take_d;

  op_t                         operation_a;
  logic signed [VALUE_W-1:0]   value_a_a, value_b_a, value_c_a, value_d_a;
  logic signed [SCORE_IN_W-1:0] score_in_a;
  logic                        not_finite_a;

  logic                        is_box;
  logic signed [V_W-1:0]       ax2, bx2, c_ext, d_ext, c_sel, d_sel;
  logic signed [V_W-1:0]       v_left, v_top, v_right, v_bottom;
  meta_t                       meta_a, meta_b, meta_c, meta_d;
  stage_t                      stage;
  result_t                     result;

  logic [SIZE_W-1:0]  left_floor, left_ceil, top_floor, top_ceil;
  logic [SIZE_W-1:0]  right_floor, right_ceil, bottom_floor, bottom_ceil;
  logic [POINT_W-1:0] lane_x, lane_y, lane_r, lane_b;

  pdd_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign take_c   = !valid_c || take_d;
  assign take_b   = !valid_b || take_c;
  assign take_a   = !valid_a || take_b;
  assign in_ready = take_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else begin
      if (take_a) valid_a <= in_valid;
      if (take_b) valid_b <= valid_a;
      if (take_c) valid_c <= valid_b;
      if (take_d) valid_d <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (take_a) begin
      operation_a  <= op_t'(operation);
      value_a_a    <= value_a;
      value_b_a    <= value_b;
      value_c_a    <= value_c;
      value_d_a    <= value_d;
      score_in_a   <= score_in;
      not_finite_a <= not_finite;
    end
    if (take_b) meta_b <= meta_a;
    if (take_c) meta_c <= meta_b;
    if (take_d) meta_d <= meta_c;
  end

  // Corners are formed as twice the centre minus or plus the size.
  always_comb begin
    is_box   = (operation_a == OP_BOX);
    ax2      = {value_a_a[VALUE_W-1], value_a_a, 1'b0};
    bx2      = {value_b_a[VALUE_W-1], value_b_a, 1'b0};
    c_ext    = V_W'(value_c_a);
    d_ext    = V_W'(value_d_a);
    c_sel    = is_box ? c_ext : '0;
    d_sel    = is_box ? d_ext : '0;
    v_left   = ax2 - c_sel;
    v_top    = bx2 - d_sel;
    v_right  = ax2 + c_ext;
    v_bottom = bx2 + d_ext;

    meta_a.op         = operation_a;
    meta_a.not_finite = not_finite_a;
    meta_a.score_in   = score_in_a;
    meta_a.drop       = is_box &&
                        (not_finite_a ||
                         ($signed({score_in_a[SCORE_IN_W-1], score_in_a}) <
                          $signed({4'b0000, cfg.score_threshold})) ||
                         value_c_a[VALUE_W-1] || (value_c_a == '0) ||
                         value_d_a[VALUE_W-1] || (value_d_a == '0));
  end

  pdd_lane #(.COORD_FRACTION_BITS(COORD_FRACTION_BITS)) u_lane_left (
    .clk (clk), .value (v_left), .is_point (!is_box), .pad (cfg.pad_left),
    .inverse_scale (cfg.inverse_scale), .image_size (cfg.image_width),
    .load_b (take_b), .load_c (take_c), .load_d (take_d),
    .edge_floor (left_floor), .edge_ceil (left_ceil), .point (lane_x)
  );

  pdd_lane #(.COORD_FRACTION_BITS(COORD_FRACTION_BITS)) u_lane_top (
    .clk (clk), .value (v_top), .is_point (!is_box), .pad (cfg.pad_top),
    .inverse_scale (cfg.inverse_scale), .image_size (cfg.image_height),
    .load_b (take_b), .load_c (take_c), .load_d (take_d),
    .edge_floor (top_floor), .edge_ceil (top_ceil), .point (lane_y)
  );

  pdd_lane #(.COORD_FRACTION_BITS(COORD_FRACTION_BITS)) u_lane_right (
    .clk (clk), .value (v_right), .is_point (1'b0), .pad (cfg.pad_left),
    .inverse_scale (cfg.inverse_scale), .image_size (cfg.image_width),
    .load_b (take_b), .load_c (take_c), .load_d (take_d),
    .edge_floor (right_floor), .edge_ceil (right_ceil), .point (lane_r)
  );

  pdd_lane #(.COORD_FRACTION_BITS(COORD_FRACTION_BITS)) u_lane_bottom (
    .clk (clk), .value (v_bottom), .is_point (1'b0), .pad (cfg.pad_top),
    .inverse_scale (cfg.inverse_scale), .image_size (cfg.image_height),
    .load_b (take_b), .load_c (take_c), .load_d (take_d),
    .edge_floor (bottom_floor), .edge_ceil (bottom_ceil), .point (lane_b)
  );

  // Only the floor of the near edges and the ceiling of the far edges are used.
  always_comb begin
    stage.meta    = meta_d;
    stage.left    = left_floor;
    stage.top     = top_floor;
    stage.right   = right_ceil;
    stage.bottom  = bottom_ceil;
    stage.point_x = lane_x;
    stage.point_y = lane_y;
  end

  pdd_decide #(.KEYPOINT_COUNT(KEYPOINT_COUNT)) u_decide (
    .clk       (clk),
    .rst       (rst),
    .valid_d   (valid_d),
    .stage     (stage),
    .take_d    (take_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign kind               = result.kind;
  assign point_number       = result.point_number;
  assign box_left           = result.box_left;
  assign box_top            = result.box_top;
  assign box_right          = result.box_right;
  assign box_bottom         = result.box_bottom;
  assign point_x            = result.point_x;
  assign point_y            = result.point_y;
  assign score              = result.score;
  assign point_present      = result.point_present;
  assign last_of_prediction = result.last_of_prediction;

endmodule
`default_nettype wire
